[sv/ssrt_pkg.sv]
// ----------------------------------------------------------------------------
// ssrt_pkg: shared types and constants of the stepper speed ramp timer
// Field widths, command and register codes, reset values, request and
// result structs, and the control state encoding.
// ----------------------------------------------------------------------------
package ssrt_pkg;

  // Speed format: unsigned Q16.SPD_FRAC steps per second
  localparam int SPD_FRAC = 8;
  localparam int SPD_W    = 16 + SPD_FRAC;
  localparam int DT_W     = 32;
  localparam int PER_W    = 32;
  localparam int FREQ_W   = 27;
  localparam int TPS_W    = 3;
  localparam int RAMP_W   = 16;
  localparam int INTV_W   = 8;
  localparam int MINRUN_W = 16;
  localparam int MINP_W   = 16;
  localparam int OP_W     = 3;
  localparam int SPS_W    = 16;

  // Divider: dividend register holds the widest dividend (target * dt)
  localparam int DEN_W = SPD_W + TPS_W;
  localparam int DVD_W = SPD_W + DT_W;
  localparam int CNT_W = $clog2(DVD_W + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = FREQ_W;

  // Command codes
  localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
  localparam logic [OP_W-1:0] OP_SPEED    = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP_REQ = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP_NOW = 3'd3;
  localparam logic [OP_W-1:0] OP_ENABLE   = 3'd4;
  localparam logic [OP_W-1:0] OP_DIR      = 3'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTV   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MINRUN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TPS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MINP   = 3'd5;

  // Reset values
  localparam logic [RAMP_W-1:0]   RST_RAMP   = 16'd0;
  localparam logic [INTV_W-1:0]   RST_INTV   = 8'd1;
  localparam logic [MINRUN_W-1:0] RST_MINRUN = 16'd1;
  localparam logic [FREQ_W-1:0]   RST_FREQ   = 27'd1000000;
  localparam logic [TPS_W-1:0]    RST_TPS    = 3'd2;
  localparam logic [MINP_W-1:0]   RST_MINP   = 16'd10;
  localparam logic [PER_W-1:0]    INIT_PERIOD = 32'd50;

  // Milliseconds per second, divisor of the minimum ramp step
  localparam logic [DEN_W-1:0] MS_PER_S = DEN_W'(1000);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_A,
    ST_DIV_B,
    ST_TIMER,
    ST_DIV_P,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [DT_W-1:0]  now_ms;
    logic [SPS_W-1:0] speed_sps;
    logic             dir_bit;
  } in_req_t;

  typedef struct packed {
    logic             serviced;
    logic             hard_stop_done;
    logic             running;
    logic [PER_W-1:0] period_ticks;
    logic [SPD_W-1:0] speed_now;
    logic             drive_enable;
    logic             direction;
    logic             step_forced_low;
  } out_rsp_t;

  // Divider launch: start pulse and number of dividend bits to process
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] len;
  } div_req_t;

endpackage

[sv/ssrt_div.sv]
// ----------------------------------------------------------------------------
// ssrt_div: bit-serial restoring divider
// One quotient bit per cycle. The dividend arrives left aligned; when done
// pulses, the low len bits of the quotient register hold the quotient.
// ----------------------------------------------------------------------------
module ssrt_div
  import ssrt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quo_o
);

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, dvd_q[DVD_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
    rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    dvd_d = {dvd_q[DVD_W-2:0], ge};
  end

  // Control: bit counter, busy and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.len;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = dvd_q;

endmodule

[sv/stepper_speed_ramp_timer.sv]
// ----------------------------------------------------------------------------
// stepper_speed_ramp_timer: linear speed ramp and step timer period
// Commands in, one status result out per command.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid_i / in_stall_o) carries one command request:
//  tick, set speed, hard stop request, hard stop now, enable, direction.
//  Output channel (out_valid_o / out_stall_i) returns one status result
//  for every command, in order. Configuration writes use cfg_valid_i /
//  cfg_ready_o; the user makes them while the block is idle (not enforced).
//  Flow: non-tick commands, ticks that fail the interval check and hard
//  stops go from acceptance straight to the output state. A serviced tick
//  with a ramp first runs a bit-serial multiply of target by dt, then two
//  passes of the shared one-bit-per-cycle divider (56 and 40 bits) for the
//  ramp step and the minimum step. With or without a ramp the timer state
//  then runs the period division (35 bits) unless it stops or saturates.
//  One command is in work at a time; the next one is accepted as soon as
//  the result sits in the output register, even while the receiver stalls.
//  Reset clears speeds, flags and time stamp, sets the period to 50 ticks
//  and loads the register defaults.
// ----------------------------------------------------------------------------
module stepper_speed_ramp_timer
  import ssrt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_req_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_rsp_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int MCNT_W = $clog2(DT_W);

  // Configuration registers
  logic [RAMP_W-1:0]   ramp_q;
  logic [INTV_W-1:0]   intv_q;
  logic [MINRUN_W-1:0] minrun_q;
  logic [FREQ_W-1:0]   freq_q;
  logic [TPS_W-1:0]    tps_q;
  logic [MINP_W-1:0]   minp_q;

  // Block state
  state_e           state_q, state_d;
  logic [SPD_W-1:0] target_q, target_d;
  logic [SPD_W-1:0] cur_q, cur_d;
  logic [DT_W-1:0]  last_q, last_d;
  logic             pend_q, pend_d;
  logic             run_q, run_d;
  logic [PER_W-1:0] period_q, period_d;
  logic             en_q, en_d;
  logic             dir_q, dir_d;

  // Per-request flags
  logic serv_q, serv_d;
  logic sdone_q, sdone_d;
  logic forced_q, forced_d;

  // Work registers
  logic [DT_W-1:0]   dt_q, dt_d;
  logic [DVD_W-1:0]  mcand_q, mcand_d;
  logic [DT_W-1:0]   mplier_q, mplier_d;
  logic [DVD_W-1:0]  prod_q, prod_d;
  logic [MCNT_W-1:0] mcnt_q, mcnt_d;
  logic [DVD_W-1:0]  a_q, a_d;
  logic              dstart_q, dstart_d;

  // Output register
  logic     out_valid_q, out_valid_d;
  out_rsp_t out_q, out_d;

  // Divider hookup
  div_req_t         div_req;
  logic [DVD_W-1:0] div_dvd;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;
  logic [DEN_W-1:0] den_p;

  logic accept;
  logic out_free;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign den_p       = DEN_W'(cur_q) * DEN_W'(tps_q);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_q   <= RST_RAMP;
      intv_q   <= RST_INTV;
      minrun_q <= RST_MINRUN;
      freq_q   <= RST_FREQ;
      tps_q    <= RST_TPS;
      minp_q   <= RST_MINP;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RAMP:   ramp_q   <= cfg_data_i[RAMP_W-1:0];
        CFG_INTV:   intv_q   <= cfg_data_i[INTV_W-1:0];
        CFG_MINRUN: minrun_q <= cfg_data_i[MINRUN_W-1:0];
        CFG_FREQ:   freq_q   <= cfg_data_i[FREQ_W-1:0];
        CFG_TPS:    tps_q    <= cfg_data_i[TPS_W-1:0];
        CFG_MINP:   minp_q   <= cfg_data_i[MINP_W-1:0];
        default: ;
      endcase
    end
  end

  // Divider operand select: ramp step, minimum step, timer period
  always_comb begin
    div_req.start = dstart_q;
    div_req.len   = CNT_W'(DVD_W);
    div_dvd       = prod_q;
    div_den       = DEN_W'(ramp_q);
    unique case (state_q)
      ST_DIV_B: begin
        div_req.len = CNT_W'(DT_W + SPD_FRAC);
        div_dvd     = {dt_q, {(DVD_W - DT_W){1'b0}}};
        div_den     = MS_PER_S;
      end
      ST_DIV_P: begin
        div_req.len = CNT_W'(FREQ_W + SPD_FRAC);
        div_dvd     = {freq_q, {(DVD_W - FREQ_W){1'b0}}};
        div_den     = den_p;
      end
      default: ;
    endcase
  end

  ssrt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dvd),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  // Next state and datapath control
  always_comb begin
    logic [DT_W-1:0]  last_eff;
    logic [DT_W-1:0]  dt;
    logic [DVD_W-1:0] step;
    logic [SPD_W-1:0] span;
    logic [PER_W-1:0] per;

    state_d     = state_q;
    target_d    = target_q;
    cur_d       = cur_q;
    last_d      = last_q;
    pend_d      = pend_q;
    run_d       = run_q;
    period_d    = period_q;
    en_d        = en_q;
    dir_d       = dir_q;
    serv_d      = serv_q;
    sdone_d     = sdone_q;
    forced_d    = forced_q;
    dt_d        = dt_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    prod_d      = prod_q;
    mcnt_d      = mcnt_q;
    a_d         = a_q;
    dstart_d    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    last_eff = (last_q == '0) ? in_data_i.now_ms : last_q;
    dt       = in_data_i.now_ms - last_eff;
    step     = (a_q > div_quo) ? a_q : div_quo;
    span     = '0;
    per      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          serv_d   = 1'b0;
          sdone_d  = 1'b0;
          forced_d = 1'b0;
          state_d  = ST_OUT;
          unique case (in_data_i.op)
            OP_TICK: begin
              last_d = last_eff;
              if (dt >= DT_W'(intv_q)) begin
                last_d = in_data_i.now_ms;
                serv_d = 1'b1;
                if (pend_q) begin
                  // pending hard stop takes this tick
                  pend_d   = 1'b0;
                  sdone_d  = 1'b1;
                  forced_d = 1'b1;
                  target_d = '0;
                  cur_d    = '0;
                  run_d    = 1'b0;
                  en_d     = 1'b0;
                end else if (ramp_q == '0) begin
                  // instant ramp whenever time has passed
                  if (dt != '0) cur_d = target_q;
                  state_d = ST_TIMER;
                end else begin
                  dt_d     = dt;
                  mcand_d  = DVD_W'(target_q);
                  mplier_d = dt;
                  prod_d   = '0;
                  mcnt_d   = MCNT_W'(DT_W - 1);
                  state_d  = ST_MUL;
                end
              end
            end
            OP_SPEED:    target_d = {in_data_i.speed_sps, {SPD_FRAC{1'b0}}};
            OP_STOP_REQ: pend_d = 1'b1;
            OP_STOP_NOW: begin
              forced_d = 1'b1;
              target_d = '0;
              cur_d    = '0;
              run_d    = 1'b0;
              en_d     = 1'b0;
            end
            OP_ENABLE:   en_d  = 1'b1;
            OP_DIR:      dir_d = in_data_i.dir_bit;
            default: ;
          endcase
        end
      end

      // target * dt, one multiplier bit per cycle
      ST_MUL: begin
        if (mplier_q[0]) prod_d = prod_q + mcand_q;
        mcand_d  = {mcand_q[DVD_W-2:0], 1'b0};
        mplier_d = {1'b0, mplier_q[DT_W-1:1]};
        mcnt_d   = mcnt_q - 1'b1;
        if (mcnt_q == '0) begin
          dstart_d = 1'b1;
          state_d  = ST_DIV_A;
        end
      end

      // ramp step = target * dt / ramp_time
      ST_DIV_A: begin
        if (div_done) begin
          a_d      = div_quo;
          dstart_d = 1'b1;
          state_d  = ST_DIV_B;
        end
      end

      // minimum step, then move current speed toward target
      ST_DIV_B: begin
        if (div_done) begin
          if (target_q > cur_q) begin
            span  = target_q - cur_q;
            cur_d = (DVD_W'(span) > step) ? cur_q + step[SPD_W-1:0] : target_q;
          end else begin
            span  = cur_q - target_q;
            cur_d = (DVD_W'(span) > step) ? cur_q - step[SPD_W-1:0] : target_q;
          end
          state_d = ST_TIMER;
        end
      end

      // below the running floor stepping stops, else set or compute the period
      ST_TIMER: begin
        if (cur_q < {minrun_q, {SPD_FRAC{1'b0}}}) begin
          run_d    = 1'b0;
          forced_d = 1'b1;
          state_d  = ST_OUT;
        end else if (den_p == '0) begin
          period_d = '1;
          run_d    = 1'b1;
          state_d  = ST_OUT;
        end else begin
          dstart_d = 1'b1;
          state_d  = ST_DIV_P;
        end
      end

      // period = (freq << frac) / (speed * toggles), saturated and floored
      ST_DIV_P: begin
        if (div_done) begin
          per      = (|div_quo[DVD_W-1:PER_W]) ? '1 : div_quo[PER_W-1:0];
          period_d = (per < PER_W'(minp_q)) ? PER_W'(minp_q) : per;
          run_d    = 1'b1;
          state_d  = ST_OUT;
        end
      end

      // load the status result once the output register is free
      ST_OUT: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.serviced        = serv_q;
          out_d.hard_stop_done  = sdone_q;
          out_d.running         = run_q;
          out_d.period_ticks    = period_q;
          out_d.speed_now       = cur_q;
          out_d.drive_enable    = en_q;
          out_d.direction       = dir_q;
          out_d.step_forced_low = forced_q;
          state_d               = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      target_q    <= '0;
      cur_q       <= '0;
      last_q      <= '0;
      pend_q      <= 1'b0;
      run_q       <= 1'b0;
      period_q    <= INIT_PERIOD;
      en_q        <= 1'b0;
      dir_q       <= 1'b0;
      serv_q      <= 1'b0;
      sdone_q     <= 1'b0;
      forced_q    <= 1'b0;
      mcnt_q      <= '0;
      dstart_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      target_q    <= target_d;
      cur_q       <= cur_d;
      last_q      <= last_d;
      pend_q      <= pend_d;
      run_q       <= run_d;
      period_q    <= period_d;
      en_q        <= en_d;
      dir_q       <= dir_d;
      serv_q      <= serv_d;
      sdone_q     <= sdone_d;
      forced_q    <= forced_d;
      mcnt_q      <= mcnt_d;
      dstart_q    <= dstart_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    dt_q     <= dt_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    prod_q   <= prod_d;
    a_q      <= a_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sv/ssrt_chk.sv]
// ----------------------------------------------------------------------------
// ssrt_chk: port-level checks of the stepper speed ramp timer
// Watches the request and result ports over time.
// ----------------------------------------------------------------------------
module ssrt_chk
  import ssrt_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input out_rsp_t              out_data_o
);

  // A stalled result holds its place and value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // One request in work at a time
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while another is in work");

  // An executed hard stop reports a stopped, disabled motor
  a_stop_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hard_stop_done |->
      out_data_o.serviced && out_data_o.step_forced_low &&
      !out_data_o.running && !out_data_o.drive_enable &&
      (out_data_o.speed_now == '0))
    else $error("hard stop result inconsistent");

  // Stepping never runs while the step pin is forced low
  a_run_forced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.running |-> !out_data_o.step_forced_low)
    else $error("running with step forced low");

endmodule

bind stepper_speed_ramp_timer ssrt_chk u_ssrt_chk (.*);
